### hdl/url_path_decode_and_check_unit_defines.svh
// Assertion helpers shared by the url path decode blocks.
// They expect clk_i and rst_ni in the scope of use.
`ifndef URL_PATH_DECODE_AND_CHECK_UNIT_DEFINES_SVH
`define URL_PATH_DECODE_AND_CHECK_UNIT_DEFINES_SVH

// Plain property, checked out of reset.
`define UPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define UPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  `UPD_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

### hdl/upd_pkg.sv
package upd_pkg;

  localparam int PATH_LIMIT     = 4096;
  localparam int CNT_W          = $clog2(PATH_LIMIT);
  localparam int ROOT_W         = 12;
  localparam int LEN_W          = 12;
  localparam int SUM_W          = ((CNT_W > ROOT_W) ? CNT_W : ROOT_W) + 2;
  localparam int INDEX_NAME_LEN = 10;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 12;

  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DEL    = 8'h7F;

  typedef enum logic [2:0] {
    ESC_IDLE = 3'b001,
    ESC_HIGH = 3'b010,
    ESC_LOW  = 3'b100
  } upd_esc_e;

  // dot run of the current segment
  typedef enum logic [1:0] {
    DOTS_NONE  = 2'd0,
    DOTS_ONE   = 2'd1,
    DOTS_TWO   = 2'd2,
    DOTS_OTHER = 2'd3
  } upd_dots_e;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_BAD_REQUEST   = 3'd1,
    ST_FORBIDDEN     = 3'd2,
    ST_TOO_LONG      = 3'd3,
    ST_ROOT_OVERFLOW = 3'd4
  } upd_status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROOT_LENGTH   = 2'd0,
    CFG_ROOT_NEEDS_SEP = 2'd1
  } upd_cfg_e;

  typedef struct packed {
    upd_esc_e         esc;
    logic [3:0]       high;
    logic [CNT_W-1:0] dec_cnt;
    logic [CNT_W-1:0] rel_cnt;
    logic             trim;
    upd_dots_e        dots;
    logic             term;
    logic             err;
    logic             trav;
    logic             last_slash;
  } upd_state_t;

  localparam upd_state_t STATE_RST = '{
    esc:        ESC_IDLE,
    high:       4'd0,
    dec_cnt:    '0,
    rel_cnt:    '0,
    trim:       1'b1,
    dots:       DOTS_NONE,
    term:       1'b0,
    err:        1'b0,
    trav:       1'b0,
    last_slash: 1'b0
  };

  typedef struct packed {
    logic [7:0]       out_byte;
    logic             byte_valid;
    logic             done_res;
    upd_status_e      status;
    logic             append_index;
    logic [LEN_W-1:0] path_length;
  } upd_res_t;

  // {valid, nibble}
  function automatic logic [4:0] hex_digit_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, c[3:0]};
    end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

### hdl/upd_if.sv
interface upd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] url_byte;
  logic       end_marker;
  modport source (output valid, url_byte, end_marker, input ready);
  modport sink   (input valid, url_byte, end_marker, output ready);
endinterface

interface upd_out_if;
  logic                     valid;
  logic                     ready;
  logic [7:0]               out_byte;
  logic                     byte_valid;
  logic                     done_res;
  logic [2:0]               status;
  logic                     append_index;
  logic [upd_pkg::LEN_W-1:0] path_length;
  modport source (output valid, out_byte, byte_valid, done_res, status, append_index,
                  path_length, input ready);
  modport sink   (input valid, out_byte, byte_valid, done_res, status, append_index,
                  path_length, output ready);
endinterface

interface upd_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [upd_pkg::CFG_IDX_W-1:0]  index;
  logic [upd_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### hdl/upd_decoder.sv
module upd_decoder (
  input  upd_pkg::upd_state_t          state_i,
  input  logic [7:0]                   url_byte_i,
  input  logic                         end_marker_i,
  input  logic [upd_pkg::ROOT_W-1:0]   root_len_i,
  input  logic                         needs_sep_i,
  output upd_pkg::upd_state_t          state_o,
  output logic                         emit_o,
  output upd_pkg::upd_res_t            res_o
);

  logic [4:0]                 hv;
  logic                       take_en;
  logic [7:0]                 take_c;
  logic                       ap;
  logic                       sep;
  logic                       end_err;
  logic                       end_trav;
  logic [upd_pkg::SUM_W-1:0]  rel_sum;
  logic [upd_pkg::SUM_W-1:0]  root_sep;
  logic [upd_pkg::SUM_W-1:0]  total;
  logic [upd_pkg::SUM_W-1:0]  lim;
  upd_pkg::upd_status_e       st;

  assign hv = upd_pkg::hex_digit_decode(url_byte_i);

  // end-of-target summary
  assign end_err  = state_i.err || (state_i.esc != upd_pkg::ESC_IDLE);
  assign end_trav = state_i.trav || (state_i.dots == upd_pkg::DOTS_TWO);
  assign ap       = (state_i.rel_cnt == '0) || state_i.last_slash;
  assign sep      = needs_sep_i && (root_len_i != '0);
  assign lim      = upd_pkg::SUM_W'(upd_pkg::PATH_LIMIT);
  assign rel_sum  = upd_pkg::SUM_W'(state_i.rel_cnt)
                  + (ap ? upd_pkg::SUM_W'(upd_pkg::INDEX_NAME_LEN) : '0);
  assign root_sep = upd_pkg::SUM_W'(root_len_i) + upd_pkg::SUM_W'(sep);
  assign total    = root_sep + rel_sum;

  always_comb begin
    if (end_err) begin
      st = upd_pkg::ST_BAD_REQUEST;
    end else if (end_trav) begin
      st = upd_pkg::ST_FORBIDDEN;
    end else if (rel_sum >= lim) begin
      st = upd_pkg::ST_TOO_LONG;
    end else if (upd_pkg::SUM_W'(root_len_i) >= lim || root_sep >= lim) begin
      st = upd_pkg::ST_ROOT_OVERFLOW;
    end else if (total >= lim) begin
      st = upd_pkg::ST_TOO_LONG;
    end else begin
      st = upd_pkg::ST_OK;
    end
  end

  always_comb begin
    state_o = state_i;
    emit_o  = 1'b0;
    res_o   = '0;
    take_en = 1'b0;
    take_c  = url_byte_i;

    if (end_marker_i) begin
      state_o           = upd_pkg::STATE_RST;
      emit_o            = 1'b1;
      res_o.done_res    = 1'b1;
      res_o.status      = st;
      if (st != upd_pkg::ST_BAD_REQUEST && st != upd_pkg::ST_FORBIDDEN) begin
        res_o.append_index = ap;
        res_o.path_length  = upd_pkg::LEN_W'(state_i.rel_cnt);
      end
    end else if (!state_i.err && !state_i.term) begin
      case (state_i.esc)
        upd_pkg::ESC_HIGH: begin
          if (hv[4]) begin
            state_o.high = hv[3:0];
            state_o.esc  = upd_pkg::ESC_LOW;
          end else begin
            state_o.err = 1'b1;
            state_o.esc = upd_pkg::ESC_IDLE;
          end
        end
        upd_pkg::ESC_LOW: begin
          state_o.esc = upd_pkg::ESC_IDLE;
          if (hv[4]) begin
            take_en = 1'b1;
            take_c  = {state_i.high, hv[3:0]};
          end else begin
            state_o.err = 1'b1;
          end
        end
        default: begin
          state_o.esc = upd_pkg::ESC_IDLE;
          if (url_byte_i == upd_pkg::CH_QMARK || url_byte_i == upd_pkg::CH_HASH) begin
            state_o.term = 1'b1;
          end else if (url_byte_i == upd_pkg::CH_PCT) begin
            state_o.esc = upd_pkg::ESC_HIGH;
          end else begin
            take_en = 1'b1;
          end
        end
      endcase
    end

    // decoded byte handling
    if (take_en) begin
      if (take_c < upd_pkg::CH_SPACE || take_c == upd_pkg::CH_DEL) begin
        state_o.err = 1'b1;
      end else begin
        if (take_c == upd_pkg::CH_BSLASH) begin
          take_c = upd_pkg::CH_SLASH;
        end
        if (state_i.dec_cnt >= upd_pkg::CNT_W'(upd_pkg::PATH_LIMIT - 1)) begin
          state_o.err = 1'b1;
        end else begin
          state_o.dec_cnt = state_i.dec_cnt + 1'b1;
          if (!(state_i.trim && take_c == upd_pkg::CH_SLASH)) begin
            state_o.trim = 1'b0;
            if (take_c == upd_pkg::CH_SLASH || take_c == upd_pkg::CH_COLON) begin
              if (state_i.dots == upd_pkg::DOTS_TWO) begin
                state_o.trav = 1'b1;
              end
              state_o.dots = upd_pkg::DOTS_NONE;
            end else if (take_c == upd_pkg::CH_DOT) begin
              case (state_i.dots)
                upd_pkg::DOTS_NONE: state_o.dots = upd_pkg::DOTS_ONE;
                upd_pkg::DOTS_ONE:  state_o.dots = upd_pkg::DOTS_TWO;
                default:            state_o.dots = upd_pkg::DOTS_OTHER;
              endcase
            end else begin
              state_o.dots = upd_pkg::DOTS_OTHER;
            end
            state_o.rel_cnt    = state_i.rel_cnt + 1'b1;
            state_o.last_slash = (take_c == upd_pkg::CH_SLASH);
            emit_o             = 1'b1;
            res_o.out_byte     = take_c;
            res_o.byte_valid   = 1'b1;
          end
        end
      end
    end
  end

endmodule

### hdl/upd_out_buf.sv
`include "url_path_decode_and_check_unit_defines.svh"

module upd_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  upd_pkg::upd_res_t res_i,
  output logic              ready_o,
  upd_out_if.source         out_o
);

  upd_pkg::upd_res_t main_q;
  upd_pkg::upd_res_t skid_q;
  logic              main_valid_q;
  logic              skid_valid_q;
  logic              pop;

  assign ready_o = !skid_valid_q;
  assign pop     = main_valid_q && out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (pop) begin
      if (skid_valid_q) begin
        skid_valid_q <= push_i;
      end else begin
        main_valid_q <= push_i;
      end
    end else if (push_i) begin
      if (main_valid_q) begin
        skid_valid_q <= 1'b1;
      end else begin
        main_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (skid_valid_q) begin
        main_q <= skid_q;
        if (push_i) begin
          skid_q <= res_i;
        end
      end else if (push_i) begin
        main_q <= res_i;
      end
    end else if (push_i) begin
      if (main_valid_q) begin
        skid_q <= res_i;
      end else begin
        main_q <= res_i;
      end
    end
  end

  assign out_o.valid        = main_valid_q;
  assign out_o.out_byte     = main_q.out_byte;
  assign out_o.byte_valid   = main_q.byte_valid;
  assign out_o.done_res     = main_q.done_res;
  assign out_o.status       = main_q.status;
  assign out_o.append_index = main_q.append_index;
  assign out_o.path_length  = main_q.path_length;

  `UPD_ASSERT(a_skid_needs_main, skid_valid_q |-> main_valid_q, "skid full with main empty")
  `UPD_ASSERT(a_no_push_when_full, !(push_i && skid_valid_q), "beat pushed into full buffer")
  `UPD_ASSERT_NEXT(a_skid_moves_up, pop && skid_valid_q, main_valid_q && main_q == $past(skid_q), "skid beat not promoted in order")

endmodule

### hdl/url_path_decode_and_check_unit.sv
// URL path decoder: takes one raw request-target byte per beat on in_i, then a
// beat with end_marker set. Each byte beat gives at most one result beat (a
// decoded, slash-trimmed path byte); the end beat always gives one summary
// beat with status, append_index and path_length, after which the path state
// is cleared. One beat is taken every cycle while in_i.ready is high; with the
// output register free, a result is presented on out_o the cycle after its
// input beat. A two-entry output buffer (main register plus skid) decouples
// the sides, so in_i.ready only drops when the sink has stalled with both
// entries full. cfg_i is always ready; write it only while the block is idle.
`include "url_path_decode_and_check_unit_defines.svh"

module url_path_decode_and_check_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  upd_in_if.sink    in_i,
  upd_out_if.source out_o,
  upd_cfg_if.sink   cfg_i
);

  logic [upd_pkg::ROOT_W-1:0] root_len_q;
  logic                       needs_sep_q;
  upd_pkg::upd_state_t        state_q;
  upd_pkg::upd_state_t        state_d;
  upd_pkg::upd_res_t          res;
  logic                       emit;
  logic                       buf_ready;
  logic                       in_acc;
  logic                       push;

  // Configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_len_q  <= upd_pkg::ROOT_W'(1);
      needs_sep_q <= 1'b0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        upd_pkg::CFG_ROOT_LENGTH:    root_len_q  <= cfg_i.data[upd_pkg::ROOT_W-1:0];
        upd_pkg::CFG_ROOT_NEEDS_SEP: needs_sep_q <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // Byte path: state advances on every accepted beat
  assign in_i.ready = buf_ready;
  assign in_acc     = in_i.valid && buf_ready;
  assign push       = in_acc && emit;

  upd_decoder u_decoder (
    .state_i      (state_q),
    .url_byte_i   (in_i.url_byte),
    .end_marker_i (in_i.end_marker),
    .root_len_i   (root_len_q),
    .needs_sep_i  (needs_sep_q),
    .state_o      (state_d),
    .emit_o       (emit),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= upd_pkg::STATE_RST;
    end else if (in_acc) begin
      state_q <= state_d;
    end
  end

  upd_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .res_i   (res),
    .ready_o (buf_ready),
    .out_o   (out_o)
  );

  // end beat always summarises and clears; byte results never carry done
  `UPD_ASSERT(a_one_kind, push |-> (res.byte_valid ^ res.done_res), "result is neither byte nor summary")
  `UPD_ASSERT_NEXT(a_end_clears, in_acc && in_i.end_marker, state_q == upd_pkg::STATE_RST, "path state not cleared after end beat")
  `UPD_ASSERT(a_quiet_after_error, in_acc && !in_i.end_marker && state_q.err |-> !emit, "byte emitted after decode error")

endmodule

### tb/sv/url_path_checker.sv
`timescale 1ns / 100ps

module url_path_checker
  import upd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  upd_in_if    in_i,
  upd_out_if   out_i,
  upd_cfg_if   cfg_i,
  output int   mismatch_count_o,
  output int   pending_o,
  output int   checked_o
);

  // register copies
  logic [ROOT_W-1:0] root_len_q;
  logic              root_sep_q;

  // path state
  upd_esc_e          esc_phase;
  logic [3:0]        hi_nib;
  logic [CNT_W-1:0]  dec_cnt;
  logic [CNT_W-1:0]  rel_cnt;
  logic              trim_lead;
  upd_dots_e         seg_dots;
  logic              term;
  logic              bad;
  logic              trav;
  logic              last_slash;

  upd_res_t          decoded_q[$];
  upd_res_t          want;
  int                mismatches;
  int                checked;

  assign mismatch_count_o = mismatches;
  assign checked_o        = checked;

  function automatic int hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    return -1;
  endfunction

  function automatic void clear_path();
    esc_phase  = ESC_IDLE;
    hi_nib     = '0;
    dec_cnt    = '0;
    rel_cnt    = '0;
    trim_lead  = 1'b1;
    seg_dots   = DOTS_NONE;
    term       = 1'b0;
    bad        = 1'b0;
    trav       = 1'b0;
    last_slash = 1'b0;
  endfunction

  function automatic void accept_decoded(input logic [7:0] raw);
    logic [7:0] c;
    upd_res_t   r;
    c = raw;
    if (c < CH_SPACE || c == CH_DEL) begin
      bad = 1'b1;
      return;
    end
    if (c == CH_BSLASH) c = CH_SLASH;
    // leading slashes count toward the decoded limit too
    if (int'(dec_cnt) + 1 >= PATH_LIMIT) begin
      bad = 1'b1;
      return;
    end
    dec_cnt++;
    if (trim_lead && c == CH_SLASH) return;
    trim_lead = 1'b0;
    if (c == CH_SLASH || c == CH_COLON) begin
      if (seg_dots == DOTS_TWO) trav = 1'b1;
      seg_dots = DOTS_NONE;
    end else if (c == CH_DOT) begin
      case (seg_dots)
        DOTS_NONE: seg_dots = DOTS_ONE;
        DOTS_ONE:  seg_dots = DOTS_TWO;
        default:   seg_dots = DOTS_OTHER;
      endcase
    end else begin
      seg_dots = DOTS_OTHER;
    end
    rel_cnt++;
    last_slash = (c == CH_SLASH);
    r = '0;
    r.out_byte   = c;
    r.byte_valid = 1'b1;
    r.status     = ST_OK;
    decoded_q.push_back(r);
  endfunction

  function automatic void finish_path();
    logic        ap;
    int          rel_total;
    int          sep;
    upd_status_e st;
    upd_res_t    r;
    if (esc_phase != ESC_IDLE) bad = 1'b1;
    if (seg_dots == DOTS_TWO) trav = 1'b1;
    ap        = (rel_cnt == '0) || last_slash;
    rel_total = int'(rel_cnt) + (ap ? INDEX_NAME_LEN : 0);
    sep       = (root_sep_q && root_len_q != '0) ? 1 : 0;
    if (bad)                                               st = ST_BAD_REQUEST;
    else if (trav)                                         st = ST_FORBIDDEN;
    else if (rel_total >= PATH_LIMIT)                      st = ST_TOO_LONG;
    else if (int'(root_len_q) + sep >= PATH_LIMIT)         st = ST_ROOT_OVERFLOW;
    else if (int'(root_len_q) + sep + rel_total >= PATH_LIMIT) st = ST_TOO_LONG;
    else                                                   st = ST_OK;
    r = '0;
    r.done_res     = 1'b1;
    r.status       = st;
    r.append_index = ap;
    r.path_length  = rel_cnt;
    if (st == ST_BAD_REQUEST || st == ST_FORBIDDEN) begin
      r.append_index = 1'b0;
      r.path_length  = '0;
    end
    decoded_q.push_back(r);
    clear_path();
  endfunction

  function automatic void decode_url_beat(input logic [7:0] c, input logic is_end);
    int h;
    if (is_end) begin
      finish_path();
      return;
    end
    if (bad || term) return;
    if (esc_phase == ESC_HIGH) begin
      h = hex_nibble(c);
      if (h < 0) begin
        bad       = 1'b1;
        esc_phase = ESC_IDLE;
      end else begin
        hi_nib    = h[3:0];
        esc_phase = ESC_LOW;
      end
      return;
    end
    if (esc_phase == ESC_LOW) begin
      h         = hex_nibble(c);
      esc_phase = ESC_IDLE;
      if (h < 0) bad = 1'b1;
      else accept_decoded({hi_nib, h[3:0]});
      return;
    end
    if (c == CH_QMARK || c == CH_HASH) term = 1'b1;
    else if (c == CH_PCT) esc_phase = ESC_HIGH;
    else accept_decoded(c);
  endfunction

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_len_q = 12'd1;
      root_sep_q = 1'b0;
      clear_path();
      decoded_q.delete();
      mismatches = 0;
      checked    = 0;
      pending_o <= 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          CFG_ROOT_LENGTH:    root_len_q = cfg_i.data[ROOT_W-1:0];
          CFG_ROOT_NEEDS_SEP: root_sep_q = cfg_i.data[0];
          default: ;
        endcase
      end
      if (in_i.valid && in_i.ready) decode_url_beat(in_i.url_byte, in_i.end_marker);
      if (out_i.valid && out_i.ready) begin
        if (decoded_q.size() == 0) begin
          $error("result beat with nothing expected");
          mismatches++;
        end else begin
          want = decoded_q.pop_front();
          check_field("out_byte",     want.out_byte,     out_i.out_byte);
          check_field("byte_valid",   want.byte_valid,   out_i.byte_valid);
          check_field("done_res",     want.done_res,     out_i.done_res);
          check_field("status",       want.status,       out_i.status);
          check_field("append_index", want.append_index, out_i.append_index);
          check_field("path_length",  want.path_length,  out_i.path_length);
          checked++;
        end
      end
      pending_o <= decoded_q.size();
    end
  end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import upd_pkg::*;

  // Run sizing. The cycle limit is well above the slowest legal run: roughly
  // 600 beats, receiver stalled 65% of the time in the first third, plus the
  // drains around each register change.
  localparam int CYCLE_LIMIT  = 40000;
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_BEATS = 500;
  localparam int N_SETTINGS   = 8;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  upd_in_if  in_if ();
  upd_out_if out_if ();
  upd_cfg_if cfg_if ();

  url_path_decode_and_check_unit dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  int mismatch_count;
  int pending;
  int checked;

  url_path_checker u_path_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_i             (in_if),
    .out_i            (out_if),
    .cfg_i            (cfg_if),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending),
    .checked_o        (checked)
  );

  // Register settings swept by the random part: both extremes of root_length,
  // a zero root with the separator flag set (no separator is added), and
  // roots near the limit so that root overflow and too long both turn up.
  int   root_set[N_SETTINGS] = '{20, 4095, 4095, 0, 1, 4000, 4086, 2048};
  logic sep_set[N_SETTINGS]  = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

  int send_idle_pct;
  int recv_idle_pct;
  int cycle_count = 0;
  int beats_sent;
  int live_beats;
  int requests_sent;
  int settings_applied;

  // bytes of the request being built; live_len excludes the ignored tail
  logic [7:0] req_bytes[$];
  int         live_len;

  always #5 clk = ~clk;

  // Receiver: ready is re-rolled every cycle, held low during reset.
  always @(posedge clk) begin
    out_if.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Request builders
  // ---------------------------------------------------------------------------

  // Printable byte that is neither an escape nor a terminator.
  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    case ($urandom_range(3))
      0: c = "a" + 8'($urandom_range(25));
      1: c = "A" + 8'($urandom_range(25));
      2: c = "0" + 8'($urandom_range(9));
      default: begin
        do c = 8'($urandom_range(32, 126));
        while (c == CH_PCT || c == CH_QMARK || c == CH_HASH);
      end
    endcase
    return c;
  endfunction

  // hex digit in a random case
  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return "0" + {4'd0, n};
    return ($urandom_range(1) ? "a" : "A") + {4'd0, n} - 8'd10;
  endfunction

  function automatic void add_escape(input logic [7:0] v);
    req_bytes.push_back(CH_PCT);
    req_bytes.push_back(hex_char(v[7:4]));
    req_bytes.push_back(hex_char(v[3:0]));
  endfunction

  function automatic void add_separator();
    case ($urandom_range(5))
      0, 1: req_bytes.push_back(CH_SLASH);
      2:    req_bytes.push_back(CH_BSLASH);
      3:    req_bytes.push_back(CH_COLON);
      4:    add_escape(CH_SLASH);
      default: add_escape(CH_BSLASH);
    endcase
  endfunction

  // Dot segments (plain and escaped) drive the traversal check; words carry
  // escapes, mostly printable, now and then any byte at all.
  function automatic void add_segment();
    case ($urandom_range(7))
      0: req_bytes.push_back(CH_DOT);
      1: begin
        req_bytes.push_back(CH_DOT);
        req_bytes.push_back(CH_DOT);
      end
      2: begin
        add_escape(CH_DOT);
        req_bytes.push_back(CH_DOT);
      end
      3: repeat (3) req_bytes.push_back(CH_DOT);
      default: begin
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(4) == 0)
            add_escape(($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                                : 8'($urandom_range(32, 126)));
          else
            req_bytes.push_back(plain_char());
        end
      end
    endcase
  endfunction

  // escape cut short by the end marker, or with a non-hex digit
  function automatic void add_broken_escape();
    logic [7:0] c;
    req_bytes.push_back(CH_PCT);
    case ($urandom_range(2))
      0: ;
      1: req_bytes.push_back(hex_char(4'($urandom_range(15))));
      default: begin
        do c = 8'($urandom_range(255));
        while (c inside {["0":"9"], ["a":"f"], ["A":"F"]});
        req_bytes.push_back(c);
        if ($urandom_range(1)) req_bytes.push_back(hex_char(4'($urandom_range(15))));
      end
    endcase
  endfunction

  // Mostly well-formed paths with random content; about one in twelve is raw
  // noise and a few more end in a broken escape.
  function automatic void build_request();
    int kind;
    int n;
    req_bytes.delete();
    kind = $urandom_range(99);
    if (kind < 8) begin
      n = $urandom_range(1, 8);
      repeat (n) req_bytes.push_back(8'($urandom_range(255)));
      live_len = n;
      return;
    end
    repeat ($urandom_range(3)) add_separator();
    n = $urandom_range(4);
    for (int i = 0; i < n; i++) begin
      if (i > 0) add_separator();
      add_segment();
    end
    if ($urandom_range(3) == 0) add_separator();
    if (kind < 20) add_broken_escape();
    live_len = req_bytes.size();
    // query or fragment: the rest of the target is ignored
    if ($urandom_range(5) == 0) begin
      req_bytes.push_back($urandom_range(1) ? CH_QMARK : CH_HASH);
      repeat ($urandom_range(4)) req_bytes.push_back(8'($urandom_range(255)));
    end
  endfunction

  function automatic void load_text(input string s);
    req_bytes.delete();
    foreach (s[i]) req_bytes.push_back(s[i]);
    live_len = req_bytes.size();
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // One beat on the input channel. valid stays high after acceptance; the next
  // call or a drain is the only thing that touches it in that step.
  task automatic send_beat(input logic [7:0] b, input logic is_end);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.url_byte   <= b;
    in_if.end_marker <= is_end;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    beats_sent++;
  endtask

  // the end beat carries a random, ignored byte
  task automatic send_request();
    foreach (req_bytes[i]) send_beat(req_bytes[i], 1'b0);
    send_beat(8'($urandom_range(255)), 1'b1);
    live_beats += live_len + 1;
    requests_sent++;
  endtask

  // Stop sending and wait for every expected beat, then leave the channel quiet.
  // The first edge lets the checker's pending count catch up.
  task automatic wait_for_drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Both registers are written back to back with valid held high.
  task automatic apply_config(input logic [ROOT_W-1:0] root, input logic sep);
    wait_for_drain();
    cfg_if.valid <= 1'b1;
    cfg_if.index <= CFG_ROOT_LENGTH;
    cfg_if.data  <= root;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.index <= CFG_ROOT_NEEDS_SEP;
    cfg_if.data  <= {{(CFG_DATA_W-1){1'b0}}, sep};
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    settings_applied++;
  endtask

  // Sender idles 10%/receiver 65%, then swapped, then no idling at all.
  task automatic pick_idle_mode();
    if (live_beats < RANDOM_BEATS / 3) begin
      send_idle_pct <= 10;
      recv_idle_pct <= 65;
    end else if (live_beats < 2 * RANDOM_BEATS / 3) begin
      send_idle_pct <= 65;
      recv_idle_pct <= 10;
    end else begin
      send_idle_pct <= 0;
      recv_idle_pct <= 0;
    end
  endtask

  initial begin
    int phase_start;
    in_if.valid      = 1'b0;
    in_if.url_byte   = '0;
    in_if.end_marker = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = CFG_ROOT_LENGTH;
    cfg_if.data      = '0;
    out_if.ready     = 1'b0;
    send_idle_pct    = 10;
    recv_idle_pct    = 65;
    beats_sent       = 0;
    live_beats       = 0;
    requests_sent    = 0;
    settings_applied = 0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed set: empty path, byte extremes, DEL via escape, trailing
    // dot-dot at the end marker, escape then query with a stray percent after
    // it, unfinished escape, backslashes as slashes.
    apply_config(12'd20, 1'b1);
    load_text("");
    send_request();
    req_bytes = {8'hFF};
    live_len  = 1;
    send_request();
    req_bytes = {8'h00};
    live_len  = 1;
    send_request();
    load_text("%7f");
    send_request();
    load_text("/..");
    send_request();
    load_text("%4a?%");
    send_request();
    load_text("%");
    send_request();
    load_text("\\x\\");
    send_request();

    // Random part, spread over the register settings. Each setting change
    // drains the block first, so the sender stalls until all results are in.
    live_beats = 0;
    for (int k = 0; k < N_SETTINGS; k++) begin
      apply_config(ROOT_W'(root_set[k]), sep_set[k]);
      phase_start = live_beats;
      while (live_beats - phase_start < RANDOM_BEATS / N_SETTINGS) begin
        pick_idle_mode();
        build_request();
        send_request();
      end
    end

    wait_for_drain();
    $display("Covered %0d requests (%0d input beats) over %0d register settings;",
             requests_sent, beats_sent, settings_applied);
    $display("%0d result beats compared, %0d mismatches.", checked, mismatch_count);
    if (mismatch_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hdl
hdl/upd_pkg.sv
hdl/upd_if.sv
hdl/upd_decoder.sv
hdl/upd_out_buf.sv
hdl/url_path_decode_and_check_unit.sv
tb/sv/url_path_checker.sv
tb/sv/tb_top.sv
